@@ design/trie_dictionary_insert_search_top_defines.svh @@
// Assertion helpers for the trie dictionary block.
// Both macros sample on the rising edge of clk and hold off during reset.
`ifndef TRIE_DICTIONARY_INSERT_SEARCH_TOP_DEFINES_SVH
`define TRIE_DICTIONARY_INSERT_SEARCH_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TDIS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdis check failed");
`define TDIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdis check failed");
`else
`define TDIS_ASSERT_IMPL(lbl, ante, cons)
`define TDIS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/tdis_pkg.sv @@
package tdis_pkg;

	// alphabet and character bounds
	localparam int ALPHABET = 26;
	localparam int IDX_W = 5;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_Z = 8'h7a;
	localparam int NODES_W = 13;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PW = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_FIN,
		S_FLAG
	} state_t;

	// classified item
	typedef struct packed {
		logic             search;
		logic             nochar;
		logic             letter;
		logic [IDX_W-1:0] idx;
		logic             last;
	} item_t;

	// front to back
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

	// back to front
	typedef struct packed {
		logic take;
		logic clearing;
	} back_ctl_t;

endpackage

@@ design/tdis_ram.sv @@
module tdis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/tdis_front.sv @@
module tdis_front
	import tdis_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       op,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       full,
	input  back_ctl_t  ctl,
	output q_out_t     q_out
);

	item_t         entry_q [Q_DEPTH];
	logic [Q_PW-1:0] wr_ptr_q;
	logic [Q_PW-1:0] rd_ptr_q;
	logic [Q_PW:0]   count_q;
	item_t         cls;
	logic          do_push;
	logic          do_pop;

	// classify the character
	always_comb begin
		cls.search = op;
		cls.nochar = (ch == 8'h00);
		cls.letter = (ch >= CH_A) && (ch <= CH_Z);
		cls.idx    = IDX_W'(ch - CH_A);
		cls.last   = last;
	end

	// no items taken while the pool is being cleared
	assign full    = (count_q == (Q_PW + 1)'(Q_DEPTH)) || ctl.clearing;
	assign do_push = push && !full;
	assign do_pop  = ctl.take && (count_q != '0);

	assign q_out.valid = (count_q != '0);
	assign q_out.item  = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/tdis_back.sv @@
module tdis_back
	import tdis_pkg::*;
#(
	parameter int MAX_NODES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_out_t             q_in,
	output back_ctl_t          ctl,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         status,
	output logic [NODES_W-1:0] nodes_used
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int TD = MAX_NODES * ALPHABET;
	localparam int AW = $clog2(TD);

	state_t  state_q, state_d;
	logic [NW-1:0] cur_q, cur_d;
	logic [CW-1:0] nf_q, nf_d;
	logic          failed_q, failed_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] slot_new;
	item_t         item_q;
	logic          ld_item;

	logic          c_we, c_re;
	logic [AW-1:0] c_waddr;
	logic [NW-1:0] c_wdata, c_rdata;
	logic          e_we, e_re;
	logic [NW-1:0] e_waddr;
	logic [0:0]    e_wdata, e_rdata;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [NODES_W-1:0] out_nodes_q;
	logic          out_free;
	logic          res_go;
	status_t       res_status;
	logic [CW+NODES_W-1:0] nodes_ext;

	// child and word-end stores
	tdis_ram #(.WIDTH(NW), .DEPTH(TD)) u_child (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (slot_new),
		.rdata (c_rdata)
	);

	tdis_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_end (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (cur_q),
		.rdata (e_rdata)
	);

	// child slot of the current node for the incoming letter
	assign slot_new = AW'(cur_q) * AW'(ALPHABET) + AW'(q_in.item.idx);
	assign out_free = !out_valid_q || pop;
	assign nodes_ext = {{NODES_W{1'b0}}, nf_q};

	// walk sequencer
	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		nf_d       = nf_q;
		failed_d   = failed_q;
		clr_d      = clr_q;
		ld_item    = 1'b0;
		ctl.take   = 1'b0;
		ctl.clearing = (state_q == S_CLEAR);
		c_we       = 1'b0;
		c_re       = 1'b0;
		c_waddr    = slot_q;
		c_wdata    = nf_q[NW-1:0];
		e_we       = 1'b0;
		e_re       = 1'b0;
		e_waddr    = cur_q;
		e_wdata    = 1'b1;
		res_go     = 1'b0;
		res_status = ST_INSERTED;
		unique case (state_q)
			S_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_wdata = '0;
				e_we    = (clr_q < AW'(MAX_NODES));
				e_waddr = clr_q[NW-1:0];
				e_wdata = 1'b0;
				if (clr_q == AW'(TD - 1)) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (q_in.valid) begin
					ctl.take = 1'b1;
					ld_item  = 1'b1;
					if (!q_in.item.nochar && !failed_q && q_in.item.letter) begin
						c_re    = 1'b1;
						state_d = S_WALK;
					end else begin
						// a non-letter fails a search, an insert skips it
						if (!q_in.item.nochar && !failed_q && q_in.item.search) begin
							failed_d = 1'b1;
						end
						if (q_in.item.last) begin
							state_d = S_FIN;
						end
					end
				end
			end
			S_WALK: begin
				if (c_rdata == '0) begin
					if (item_q.search || (nf_q == CW'(MAX_NODES))) begin
						failed_d = 1'b1;
					end else begin
						c_we  = 1'b1;
						cur_d = nf_q[NW-1:0];
						nf_d  = nf_q + 1'b1;
					end
				end else begin
					cur_d = c_rdata;
				end
				state_d = item_q.last ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				if (item_q.search && !failed_q) begin
					e_re    = 1'b1;
					state_d = S_FLAG;
				end else if (out_free) begin
					res_go = 1'b1;
					if (item_q.search) begin
						res_status = ST_NOT_FOUND;
					end else if (failed_q) begin
						res_status = ST_OVERFLOW;
					end else begin
						res_status = ST_INSERTED;
						e_we       = 1'b1;
					end
					cur_d    = '0;
					failed_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			S_FLAG: begin
				if (out_free) begin
					res_go     = 1'b1;
					res_status = e_rdata[0] ? ST_FOUND : ST_NOT_FOUND;
					cur_d      = '0;
					failed_d   = 1'b0;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cur_q       <= '0;
			nf_q        <= CW'(1);
			failed_q    <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cur_q    <= cur_d;
			nf_q     <= nf_d;
			failed_q <= failed_d;
			clr_q    <= clr_d;
			if (res_go) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (ld_item) begin
			item_q <= q_in.item;
			slot_q <= slot_new;
		end
		if (res_go) begin
			out_status_q <= res_status;
			out_nodes_q  <= nodes_ext[NODES_W-1:0];
		end
	end

	assign empty      = !out_valid_q;
	assign status     = out_status_q;
	assign nodes_used = out_nodes_q;

endmodule

@@ design/trie_dictionary_insert_search_top.sv @@
// Trie dictionary over the letters a to z, fed one character per item:
// push op (0 insert, 1 search), ch and last; a result (status, nodes_used)
// is queued only for the item marked last. After reset the block runs a
// clearing pass over the child table and the word-end store, with full held
// high. Afterwards a letter goes through the walk sequencer as a registered
// child-table read, then the follow or allocate step; a zero byte, or a
// skipped or failed character, needs only the idle step. A last item adds a
// finish step, and a search that reached a node adds a word-end flag read.
// A two-item queue keeps push open while the walk runs, and one output
// register holds a result until it is popped.
`include "trie_dictionary_insert_search_top_defines.svh"

module trie_dictionary_insert_search_top
	import tdis_pkg::*;
#(
	parameter int MAX_NODES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic [NODES_W-1:0] nodes_used
);

	q_out_t    q_out;
	back_ctl_t ctl;

	// accept and classify
	tdis_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.op     (op),
		.ch     (ch),
		.last   (last),
		.full   (full),
		.ctl    (ctl),
		.q_out  (q_out)
	);

	// walk the trie and deliver results
	tdis_back #(.MAX_NODES(MAX_NODES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_in       (q_out),
		.ctl        (ctl),
		.pop        (pop),
		.empty      (empty),
		.status     (status),
		.nodes_used (nodes_used)
	);

	// checks
	`TDIS_ASSERT_IMPL(a_clear_blocks_push, ctl.clearing, full)
	`TDIS_ASSERT_IMPL(a_take_needs_item, ctl.take, q_out.valid)
	`TDIS_ASSERT_IMPL(a_no_take_in_clear, ctl.clearing, !ctl.take)
	`TDIS_ASSERT_NEXT(a_clear_no_result, ctl.clearing, empty)

endmodule

@@ tb/tb_trie_dictionary_insert_search_top.sv @@
module tb_trie_dictionary_insert_search_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tdis_pkg::*;

	localparam int POOL = 4096;
	localparam int SPELL_MAX = 64;
	localparam int VOCAB = 24;
	localparam int LIMIT = 3000000;
	localparam int DRAIN = 100;
	localparam int LONG_HOLD = 600;
	localparam int HOLD_AT = 30;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam int KIND_INSERT = 0;
	localparam int KIND_SEARCH = 1;
	localparam int KIND_MIXED = 2;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		status_t            status;
		logic [NODES_W-1:0] nodes;
	} word_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic op = 1'b0;
	logic [7:0] ch = 8'h00;
	logic last = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [1:0] status;
	logic [NODES_W-1:0] nodes_used;

	trie_dictionary_insert_search_top #(
		.MAX_NODES(POOL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.ch(ch),
		.last(last),
		.empty(empty),
		.pop(pop),
		.status(status),
		.nodes_used(nodes_used)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// trie mirror
	bit [11:0] child_of [POOL*ALPHABET];
	bit word_end [POOL];
	int free_node = 1;
	int walk_node = 0;
	bit walk_failed = 1'b0;

	char_item_t pending[$];
	word_result_t results_due[$];
	int errors = 0;
	int words_seen = 0;

	// stimulus scratch
	logic [7:0] vocab_chr [VOCAB][SPELL_MAX];
	int vocab_len [VOCAB];
	logic [7:0] spell [SPELL_MAX];
	int spell_len = 0;

	// idling control
	int gap_left = 0;
	int stall_left = 0;
	bit send_steady = 1'b0;
	bit take_steady = 1'b0;
	bit held_once = 1'b0;
	char_item_t next_up;

	// advance the walk by one character; queue the word result on the last one
	function automatic void trie_walk(input logic is_search, input logic [7:0] c,
			input logic is_last);
		logic [IDX_W-1:0] idx;
		int slot;
		int kid;
		status_t st;
		if (c != 8'h00 && !walk_failed) begin
			if (c < CH_A || c > CH_Z) begin
				if (is_search)
					walk_failed = 1'b1;
			end else begin
				idx = IDX_W'(c - CH_A);
				slot = walk_node * ALPHABET + int'(idx);
				kid = int'(child_of[slot]);
				if (kid != 0) begin
					walk_node = kid;
				end else if (is_search || free_node >= POOL) begin
					walk_failed = 1'b1;
				end else begin
					child_of[slot] = 12'(free_node);
					walk_node = free_node;
					free_node++;
				end
			end
		end
		if (is_last) begin
			if (is_search)
				st = (!walk_failed && word_end[walk_node]) ? ST_FOUND : ST_NOT_FOUND;
			else if (walk_failed)
				st = ST_OVERFLOW;
			else begin
				word_end[walk_node] = 1'b1;
				st = ST_INSERTED;
			end
			results_due.push_back('{st, NODES_W'(free_node)});
			walk_node = 0;
			walk_failed = 1'b0;
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 45)
			return 0;
		if (r < 85)
			return int'($urandom_range(1, 3));
		if (r < 97)
			return int'($urandom_range(4, 12));
		return int'($urandom_range(25, 80));
	endfunction

	function automatic void queue_item(input logic o, input logic [7:0] c, input logic l);
		pending.push_back('{o, c, l});
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(int'(CH_A), int'(CH_A) + 4));
		return 8'($urandom_range(int'(CH_A), int'(CH_Z)));
	endfunction

	// any nonzero byte outside a to z
	function automatic logic [7:0] junk_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c >= CH_A && c <= CH_Z);
		return c;
	endfunction

	function automatic logic pick_op(input int kind);
		if (kind == KIND_MIXED)
			return 1'($urandom_range(0, 1));
		return (kind == KIND_SEARCH) ? OP_SEARCH : OP_INSERT;
	endfunction

	function automatic void make_word(input int len, input bit wide);
		for (int i = 0; i < len; i++)
			spell[i] = wide ? 8'($urandom_range(int'(CH_A), int'(CH_Z))) : rand_letter();
		spell_len = len;
	endfunction

	// copy a dictionary word, sometimes cut to a prefix or grown by a letter
	function automatic void load_vocab(input int k);
		int r;
		spell_len = vocab_len[k];
		for (int i = 0; i < spell_len; i++)
			spell[i] = vocab_chr[k][i];
		r = int'($urandom_range(0, 9));
		if (r == 0)
			spell_len = int'($urandom_range(0, spell_len));
		else if (r == 1 && spell_len < SPELL_MAX) begin
			spell[spell_len] = rand_letter();
			spell_len++;
		end
	endfunction

	function automatic void send_spell(input int kind, input bit noisy, input bit trail);
		logic o;
		for (int i = 0; i < spell_len; i++) begin
			o = pick_op(kind);
			if (noisy && $urandom_range(0, 5) == 0)
				queue_item(o, ($urandom_range(0, 2) == 0) ? 8'h00 : junk_byte(), 1'b0);
			queue_item(o, spell[i], (i == spell_len - 1) && !trail);
		end
		if (trail || spell_len == 0)
			queue_item(pick_op(kind), 8'h00, 1'b1);
	endfunction

	// random bytes and ops, ended by a last item
	function automatic void send_broken();
		int n;
		int r;
		logic [7:0] c;
		n = int'($urandom_range(1, 5));
		for (int i = 0; i < n; i++) begin
			r = int'($urandom_range(0, 3));
			if (r < 2)
				c = rand_letter();
			else if (r == 2)
				c = junk_byte();
			else
				c = 8'($urandom_range(0, 255));
			queue_item(1'($urandom_range(0, 1)), c, i == n - 1);
		end
	endfunction

	// well-formed words over a small dictionary, with some noise
	function automatic void random_words(input int budget);
		int start;
		int r;
		int kind;
		start = pending.size();
		while (pending.size() - start < budget) begin
			if ($urandom_range(0, 4) == 0) begin
				send_broken();
			end else begin
				if ($urandom_range(0, 9) < 7)
					load_vocab(int'($urandom_range(0, VOCAB - 1)));
				else
					make_word(int'($urandom_range(0, 8)), $urandom_range(0, 1) == 1);
				r = int'($urandom_range(0, 99));
				kind = (r < 40) ? KIND_INSERT : (r < 85) ? KIND_SEARCH : KIND_MIXED;
				send_spell(kind, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
			end
		end
	endfunction

	// sender: holds an item until accepted, then waits out a gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			op <= 1'b0;
			ch <= 8'h00;
			last <= 1'b0;
		end else begin
			if (push && !full) begin
				trie_walk(op, ch, last);
				gap_left = send_steady ? 0 : pick_gap();
				if ($urandom_range(0, 49) == 0)
					send_steady = !send_steady;
			end
			if (!push || !full) begin
				if (gap_left > 0 || pending.size() == 0) begin
					push <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					next_up = pending.pop_front();
					push <= 1'b1;
					op <= next_up.op;
					ch <= next_up.ch;
					last <= next_up.last;
				end
			end
		end
	end

	// receiver: checks each word result, stalls at random, once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: status %0d nodes_used %0d", status, nodes_used);
					errors++;
				end else begin
					if (status !== results_due[0].status) begin
						$error("status: expected %0d, actual %0d",
							results_due[0].status, status);
						errors++;
					end
					if (nodes_used !== results_due[0].nodes) begin
						$error("nodes_used: expected %0d, actual %0d",
							results_due[0].nodes, nodes_used);
						errors++;
					end
					void'(results_due.pop_front());
				end
				words_seen++;
				stall_left = take_steady ? 0 : pick_gap();
				if ($urandom_range(0, 49) == 0)
					take_steady = !take_steady;
				if (words_seen == HOLD_AT && !held_once) begin
					stall_left = LONG_HOLD;
					held_once = 1'b1;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("trie_dictionary_insert_search_top: mismatch");
		$finish;
	end

	initial begin
		// small dictionary with shared prefixes
		for (int k = 0; k < VOCAB; k++) begin
			make_word(int'($urandom_range(1, 8)), $urandom_range(0, 3) == 0);
			vocab_len[k] = spell_len;
			for (int i = 0; i < spell_len; i++)
				vocab_chr[k][i] = spell[i];
		end

		// empty word: search before and after it is stored
		queue_item(OP_SEARCH, 8'h00, 1'b1);
		queue_item(OP_INSERT, 8'h00, 1'b1);
		queue_item(OP_SEARCH, 8'h00, 1'b1);
		// both letter bounds
		queue_item(OP_INSERT, CH_A, 1'b0);
		queue_item(OP_INSERT, CH_Z, 1'b1);
		// no character inside a search
		queue_item(OP_SEARCH, CH_A, 1'b0);
		queue_item(OP_SEARCH, 8'h00, 1'b0);
		queue_item(OP_SEARCH, CH_Z, 1'b1);
		// prefix only
		queue_item(OP_SEARCH, CH_A, 1'b1);
		// insert skips bytes just outside the letters and the top byte
		queue_item(OP_INSERT, CH_A, 1'b0);
		queue_item(OP_INSERT, 8'hff, 1'b0);
		queue_item(OP_INSERT, CH_A - 8'd1, 1'b0);
		queue_item(OP_INSERT, CH_Z + 8'd1, 1'b0);
		queue_item(OP_INSERT, CH_Z, 1'b1);
		// search fails on a non-letter
		queue_item(OP_SEARCH, CH_A, 1'b0);
		queue_item(OP_SEARCH, 8'h41, 1'b1);
		// search fails on a missing child
		queue_item(OP_SEARCH, "b", 1'b1);
		// failed search then a last insert
		queue_item(OP_SEARCH, "q", 1'b0);
		queue_item(OP_INSERT, CH_A, 1'b1);
		// insert then search within one word
		queue_item(OP_INSERT, "b", 1'b0);
		queue_item(OP_SEARCH, "b", 1'b1);
		// walk stays put after a failure
		queue_item(OP_SEARCH, "x", 1'b0);
		queue_item(OP_SEARCH, CH_A, 1'b1);

		random_words(400);

		// a few long inserts for deep walks
		for (int w = 0; w < 4; w++) begin
			make_word(SPELL_MAX, 1'b1);
			send_spell(KIND_INSERT, 1'b0, 1'b0);
		end

		// more words over the grown trie
		random_words(60);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending.size() != 0 || push || results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);

		if (!empty) begin
			$error("unexpected result left at the output");
			errors++;
		end
		if (errors == 0 && results_due.size() == 0)
			$display("trie_dictionary_insert_search_top: match");
		else
			$display("trie_dictionary_insert_search_top: mismatch");
		$finish;
	end

endmodule
